// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk, disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qrv_pkg.sv =====
package qrv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ADDR_W = 3;
  localparam logic [15:0] THRESH_RESET = 16'd1;
  // register index as seen in paddr[2]
  localparam logic REG_THRESH = 1'b0;
  localparam int DIV_STEPS = 31;

  typedef struct packed {
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               degenerate;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } quat_t;

  // floor-shifted and clipped sum
  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } fin_t;

  // side data carried down the divider
  typedef struct packed {
    quat_t q;
    quat_t t;
    logic  degen;
    logic  sat;
    logic  rsat;
  } div_pl_t;

endpackage

// ===== rtl/quaternion_rotate_vector.sv =====
// Quaternion vector rotation, signed fixed point with FRAC_BITS fraction bits.
// Command channel: item is taken at a rising edge where start is high and busy
// is low. busy is high only during reset, so one item may be taken every cycle.
// Result channel: done is high for exactly one cycle with result; the receiver
// cannot stall, and there is no backpressure anywhere in the block.
// Pipeline: 3 stages for the products, sums and divider setup, 31
// restoring-division stages for the reciprocal of the squared length, then
// 4 stages for q*reciprocal, the inverse, the second products and the final
// sums. Throughput: one per cycle.
// The 31-step reciprocal divider, one quotient bit per stage, sets the depth.
// Config: APB, one register, degenerate_threshold at byte address 0, 16 bits,
// reset value 1. pready is tied high. Write it only when the pipe is empty.
// Reset (synchronous rst) drops every item in flight and restores the register.
// degenerate flags a squared length at or below the threshold (inverse taken
// as identity); saturated flags any value clipped to 32 bits along the way.
`include "assert_macros.svh"

module quaternion_rotate_vector #(
  parameter int FRAC_BITS = qrv_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  qrv_pkg::item_t              item,
  output logic                        done,
  output qrv_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qrv_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int NSTEP = qrv_pkg::DIV_STEPS;
  // 2^(2F), the reciprocal numerator
  localparam logic [63:0] NUM = 64'd1 << (2 * FRAC_BITS);
  // remainder entering quotient bit 30
  localparam logic [30:0] R0 = 31'(NUM >> 31);
  localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [31:0] MAXV = 32'sh7fffffff;

  function automatic logic signed [63:0] mul(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    mul = a * b;
  endfunction

  // floor shift by FRAC_BITS, clip to 32 bits
  function automatic qrv_pkg::fin_t fin(input logic signed [65:0] s);
    logic signed [65:0] sh;
    qrv_pkg::fin_t f;
    sh = s >>> FRAC_BITS;
    if (sh > 66'sd2147483647) begin
      f.val  = MAXV;
      f.clip = 1'b1;
    end else if (sh < -66'sd2147483648) begin
      f.val  = 32'sh80000000;
      f.clip = 1'b1;
    end else begin
      f.val  = 32'(sh);
      f.clip = 1'b0;
    end
    return f;
  endfunction

  // ---------------- config register ----------------
  logic [15:0] thresh;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == qrv_pkg::REG_THRESH);
  assign prdata = (paddr[2] == qrv_pkg::REG_THRESH) ? {16'd0, thresh} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= qrv_pkg::THRESH_RESET;
    end else if (cfg_wr) begin
      thresh <= pwdata[15:0];
    end
  end

  assign busy = rst;

  // ---------------- stage 1: squares and q*(v,0) products ----------------
  logic               v1;
  logic signed [63:0] sq1 [4];
  logic signed [63:0] pt1 [12];
  qrv_pkg::quat_t     q1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    q1     <= '{x: item.quat_x, y: item.quat_y, z: item.quat_z, w: item.quat_w};
    sq1[0] <= mul(item.quat_x, item.quat_x);
    sq1[1] <= mul(item.quat_y, item.quat_y);
    sq1[2] <= mul(item.quat_z, item.quat_z);
    sq1[3] <= mul(item.quat_w, item.quat_w);
    pt1[0]  <= mul(item.quat_w, item.vec_x);
    pt1[1]  <= mul(item.quat_y, item.vec_z);
    pt1[2]  <= mul(item.quat_z, item.vec_y);
    pt1[3]  <= mul(item.quat_w, item.vec_y);
    pt1[4]  <= mul(item.quat_x, item.vec_z);
    pt1[5]  <= mul(item.quat_z, item.vec_x);
    pt1[6]  <= mul(item.quat_w, item.vec_z);
    pt1[7]  <= mul(item.quat_x, item.vec_y);
    pt1[8]  <= mul(item.quat_y, item.vec_x);
    pt1[9]  <= mul(item.quat_x, item.vec_x);
    pt1[10] <= mul(item.quat_y, item.vec_y);
    pt1[11] <= mul(item.quat_z, item.vec_z);
  end

  // ---------------- stage 2: sums, shift, clip ----------------
  qrv_pkg::fin_t len_f, t0_f, t1_f, t2_f, t3_f;

  always_comb begin
    len_f = fin(66'(sq1[0]) + 66'(sq1[1]) + 66'(sq1[2]) + 66'(sq1[3]));
    t0_f  = fin(66'(pt1[0]) + 66'(pt1[1]) - 66'(pt1[2]));
    t1_f  = fin(66'(pt1[3]) - 66'(pt1[4]) + 66'(pt1[5]));
    t2_f  = fin(66'(pt1[6]) + 66'(pt1[7]) - 66'(pt1[8]));
    t3_f  = fin(-66'(pt1[9]) - 66'(pt1[10]) - 66'(pt1[11]));
  end

  logic               v2;
  logic signed [31:0] len2;
  qrv_pkg::quat_t     q2, t2;
  logic               clip2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    len2  <= len_f.val;
    q2    <= q1;
    t2    <= '{x: t0_f.val, y: t1_f.val, z: t2_f.val, w: t3_f.val};
    clip2 <= len_f.clip | t0_f.clip | t1_f.clip | t2_f.clip | t3_f.clip;
  end

  // ---------------- stage 3: degenerate test, divider setup ----------------
  logic            degen3, rsat3;
  assign degen3 = $unsigned(len2) <= {16'd0, thresh};
  assign rsat3  = R0 >= len2[30:0];

  // index 0 is the setup register, index k+1 follows quotient step k
  logic                 div_v   [NSTEP+1];
  logic [30:0]          div_r   [NSTEP+1];
  logic [30:0]          div_quo [NSTEP+1];
  logic [30:0]          div_l   [NSTEP+1];
  qrv_pkg::div_pl_t     div_pl  [NSTEP+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_v[0] <= 1'b0;
    end else begin
      div_v[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    div_r[0]   <= R0;
    div_quo[0] <= '0;
    div_l[0]   <= len2[30:0];
    div_pl[0]  <= '{q: q2, t: t2, degen: degen3,
                    sat: clip2 | (~degen3 & rsat3), rsat: rsat3};
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  for (genvar k = 0; k < NSTEP; k++) begin : g_div
    localparam int BIT = NSTEP - 1 - k;
    logic [31:0] rs;
    logic        ge;
    logic [31:0] diff;
    logic [30:0] qn;

    assign rs   = {div_r[k], NUM[BIT]};
    assign ge   = rs >= {1'b0, div_l[k]};
    assign diff = rs - {1'b0, div_l[k]};
    assign qn   = div_quo[k] | (31'(ge) << BIT);

    always_ff @(posedge clk) begin
      if (rst) begin
        div_v[k+1] <= 1'b0;
      end else begin
        div_v[k+1] <= div_v[k];
      end
    end

    always_ff @(posedge clk) begin
      div_r[k+1]   <= ge ? diff[30:0] : rs[30:0];
      div_quo[k+1] <= qn;
      div_l[k+1]   <= div_l[k];
      div_pl[k+1]  <= div_pl[k];
    end
  end

  // ---------------- stage 4: q * reciprocal ----------------
  qrv_pkg::div_pl_t   pl_d;
  logic signed [31:0] rcp;

  assign pl_d = div_pl[NSTEP];
  assign rcp  = pl_d.rsat ? MAXV : $signed({1'b0, div_quo[NSTEP]});

  logic               v4;
  logic signed [63:0] pi4 [4];
  qrv_pkg::div_pl_t   pl4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= div_v[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    pl4    <= pl_d;
    pi4[0] <= mul(pl_d.q.x, rcp);
    pi4[1] <= mul(pl_d.q.y, rcp);
    pi4[2] <= mul(pl_d.q.z, rcp);
    pi4[3] <= mul(pl_d.q.w, rcp);
  end

  // ---------------- stage 5: inverse quaternion ----------------
  qrv_pkg::fin_t ix_f, iy_f, iz_f, iw_f;

  always_comb begin
    ix_f = fin(-66'(pi4[0]));
    iy_f = fin(-66'(pi4[1]));
    iz_f = fin(-66'(pi4[2]));
    iw_f = fin(66'(pi4[3]));
  end

  logic               v5;
  qrv_pkg::quat_t     inv5, t5;
  logic               degen5, sat5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    t5     <= pl4.t;
    degen5 <= pl4.degen;
    if (pl4.degen) begin
      inv5 <= '{x: 32'sd0, y: 32'sd0, z: 32'sd0, w: ONE};
      sat5 <= pl4.sat;
    end else begin
      inv5 <= '{x: ix_f.val, y: iy_f.val, z: iz_f.val, w: iw_f.val};
      sat5 <= pl4.sat | ix_f.clip | iy_f.clip | iz_f.clip | iw_f.clip;
    end
  end

  // ---------------- stage 6: t * inverse products ----------------
  logic               v6;
  logic signed [63:0] pr6 [12];
  logic               degen6, sat6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    degen6  <= degen5;
    sat6    <= sat5;
    pr6[0]  <= mul(t5.w, inv5.x);
    pr6[1]  <= mul(t5.x, inv5.w);
    pr6[2]  <= mul(t5.y, inv5.z);
    pr6[3]  <= mul(t5.z, inv5.y);
    pr6[4]  <= mul(t5.w, inv5.y);
    pr6[5]  <= mul(t5.x, inv5.z);
    pr6[6]  <= mul(t5.y, inv5.w);
    pr6[7]  <= mul(t5.z, inv5.x);
    pr6[8]  <= mul(t5.w, inv5.z);
    pr6[9]  <= mul(t5.x, inv5.y);
    pr6[10] <= mul(t5.y, inv5.x);
    pr6[11] <= mul(t5.z, inv5.w);
  end

  // ---------------- stage 7: final sums, result register ----------------
  qrv_pkg::fin_t rx_f, ry_f, rz_f;

  always_comb begin
    rx_f = fin(66'(pr6[0]) + 66'(pr6[1]) + 66'(pr6[2]) - 66'(pr6[3]));
    ry_f = fin(66'(pr6[4]) - 66'(pr6[5]) + 66'(pr6[6]) + 66'(pr6[7]));
    rz_f = fin(66'(pr6[8]) + 66'(pr6[9]) - 66'(pr6[10]) + 66'(pr6[11]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v6;
    end
  end

  always_ff @(posedge clk) begin
    result <= '{out_x: rx_f.val, out_y: ry_f.val, out_z: rz_f.val,
                degenerate: degen6,
                saturated: sat6 | rx_f.clip | ry_f.clip | rz_f.clip};
  end

  // ---------------- assertions ----------------
  `ASSERT_IMPLIES(a_div_rem, div_v[NSTEP] && !div_pl[NSTEP].degen && !div_pl[NSTEP].rsat, div_r[NSTEP] < div_l[NSTEP], "divider remainder not below divisor")
  `ASSERT_IMPLIES(a_degen_ident, v5 && degen5, inv5.x == 32'sd0 && inv5.y == 32'sd0 && inv5.z == 32'sd0 && inv5.w == ONE, "degenerate inverse is not identity")
  `ASSERT_NEXT(a_last_stage, v6, done, "result strobe missing after last stage")

endmodule
